// File: design/cfrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfrl_pkg
// Shared types and constants for the chat flood rate limiter.
// ----------------------------------------------------------------------------
package cfrl_pkg;

  localparam int TICK_WIDTH_DEF = 32;

  localparam int NOW_W   = 32;
  localparam int CNT_W   = 16;
  localparam int SPAN_W  = 15;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // action modes
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_DROP     = 2'd1;
  localparam logic [1:0] MODE_REDIRECT = 2'd2;
  localparam logic [1:0] MODE_DETECT   = 2'd3;

  // verdict codes
  localparam logic [1:0] VERDICT_DELIVER  = 2'd0;
  localparam logic [1:0] VERDICT_DROP     = 2'd1;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ACTION_MODE   = 3'd0;
  localparam logic [2:0] REG_WINDOW_TICKS  = 3'd1;
  localparam logic [2:0] REG_MESSAGE_LIMIT = 3'd2;
  localparam logic [2:0] REG_LOCK_TICKS    = 3'd3;
  localparam logic [2:0] REG_REPORT_ENABLE = 3'd4;

  // register reset values
  localparam logic [1:0]        RST_ACTION_MODE   = MODE_OFF;
  localparam logic [SPAN_W-1:0] RST_WINDOW_TICKS  = 15'd5;
  localparam logic [SPAN_W-1:0] RST_MESSAGE_LIMIT = 15'd5;
  localparam logic [SPAN_W-1:0] RST_LOCK_TICKS    = 15'd15;
  localparam logic              RST_REPORT_ENABLE = 1'b1;

  typedef struct packed {
    logic [1:0] verdict;
    logic       flood_report;
  } result_t;

endpackage : cfrl_pkg
`default_nettype wire

// File: design/chat_flood_rate_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chat_flood_rate_limiter
// Fixed-window message counter with lockout; gives a verdict per message.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one request per chat message; in_tdata carries the
//   current tick, in_tuser the exempt-sender flag.
//   Output stream (out_*): one result per message, in order; out_tdata holds
//   the verdict (deliver, drop, redirect), out_tuser the flood report flag.
//   APB port (cfg_*): action mode, window length, message limit, lock length
//   and report enable at byte addresses 0x00..0x10; pready is always high.
//   Write registers only while no message is in flight.
// Timing:
//   The verdict is computed in the accept cycle from the state registers and
//   the request, and is registered into a two-entry result queue; throughput
//   is 1 message per cycle while in_tready is high, set by the state update.
//   When the receiver stalls, the queue absorbs one more message; in_tready
//   drops only once both entries are full.
// Reset:
//   rst_n (synchronous, active low) clears the counter, window, lock and the
//   queue, and loads the register defaults (mode off, 5, 5, 15, report on).
// ----------------------------------------------------------------------------
module chat_flood_rate_limiter #(
  parameter int TICK_WIDTH = cfrl_pkg::TICK_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // input stream
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [31:0]                 in_tdata,   // [31:0] now_tick
  input  wire  [0:0]                  in_tuser,   // [0] sender_exempt
  // result stream
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [7:0]                  out_tdata,  // [1:0] verdict, [7:2] zero
  output logic [0:0]                  out_tuser,  // [0] flood_report
  // configuration
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire  [cfrl_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire  [cfrl_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [cfrl_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NW = (TICK_WIDTH < cfrl_pkg::NOW_W) ? TICK_WIDTH : cfrl_pkg::NOW_W;
  localparam int SW = NW + 1;
  localparam int SP = cfrl_pkg::SPAN_W;
  localparam int CW = cfrl_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]    action_mode_r;
  logic [SP-1:0] window_ticks_r;
  logic [SP-1:0] message_limit_r;
  logic [SP-1:0] lock_ticks_r;
  logic          report_enable_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_mode_r   <= cfrl_pkg::RST_ACTION_MODE;
      window_ticks_r  <= cfrl_pkg::RST_WINDOW_TICKS;
      message_limit_r <= cfrl_pkg::RST_MESSAGE_LIMIT;
      lock_ticks_r    <= cfrl_pkg::RST_LOCK_TICKS;
      report_enable_r <= cfrl_pkg::RST_REPORT_ENABLE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cfrl_pkg::REG_ACTION_MODE:   action_mode_r   <= cfg_pwdata[1:0];
        cfrl_pkg::REG_WINDOW_TICKS:  window_ticks_r  <= cfg_pwdata[SP-1:0];
        cfrl_pkg::REG_MESSAGE_LIMIT: message_limit_r <= cfg_pwdata[SP-1:0];
        cfrl_pkg::REG_LOCK_TICKS:    lock_ticks_r    <= cfg_pwdata[SP-1:0];
        cfrl_pkg::REG_REPORT_ENABLE: report_enable_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      cfrl_pkg::REG_ACTION_MODE:   cfg_prdata[1:0]    = action_mode_r;
      cfrl_pkg::REG_WINDOW_TICKS:  cfg_prdata[SP-1:0] = window_ticks_r;
      cfrl_pkg::REG_MESSAGE_LIMIT: cfg_prdata[SP-1:0] = message_limit_r;
      cfrl_pkg::REG_LOCK_TICKS:    cfg_prdata[SP-1:0] = lock_ticks_r;
      cfrl_pkg::REG_REPORT_ENABLE: cfg_prdata[0]      = report_enable_r;
      default:                     cfg_prdata         = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // limiter state and single-pass update
  // --------------------------------------------------------------------------
  logic [CW-1:0] msg_count_r, msg_count_nxt;
  logic [NW-1:0] window_start_r, window_start_nxt;
  logic [NW-1:0] lock_start_r, lock_start_nxt;
  logic          lock_active_r, lock_active_nxt;

  logic              push, pop;
  logic [NW-1:0]     now;
  logic              limiting;
  logic              cnt_zero, win_expired, over_limit, lock_in_force;
  logic [CW-1:0]     cnt_base;
  logic [NW-1:0]     ls_base;
  logic              la_base, la_over;
  logic [SW-1:0]     win_end, lock_end;
  cfrl_pkg::result_t res;

  assign now      = in_tdata[NW-1:0];
  assign limiting = !in_tuser[0] && (action_mode_r != cfrl_pkg::MODE_OFF);
  assign push     = in_tvalid && in_tready;

  always_comb begin
    cnt_zero      = (msg_count_r == '0);
    win_end       = {1'b0, window_start_r} + SW'(window_ticks_r);
    win_expired   = !cnt_zero && (win_end < {1'b0, now});
    window_start_nxt = (cnt_zero || win_expired) ? now : window_start_r;
    ls_base       = cnt_zero ? now : lock_start_r;
    la_base       = cnt_zero ? 1'b0 : lock_active_r;
    cnt_base      = win_expired ? '0 : msg_count_r;
    msg_count_nxt = cnt_base + CW'(1);
    over_limit    = msg_count_nxt > CW'(message_limit_r);
    lock_start_nxt = over_limit ? now : ls_base;
    la_over       = over_limit || la_base;
    lock_end      = {1'b0, lock_start_nxt} + SW'(lock_ticks_r);
    lock_in_force = lock_end > {1'b0, now};
    lock_active_nxt = la_over && lock_in_force;

    res.flood_report = limiting && over_limit && !la_base && report_enable_r;
    res.verdict      = cfrl_pkg::VERDICT_DELIVER;
    if (limiting && lock_active_nxt) begin
      case (action_mode_r)
        cfrl_pkg::MODE_DROP:     res.verdict = cfrl_pkg::VERDICT_DROP;
        cfrl_pkg::MODE_REDIRECT: res.verdict = cfrl_pkg::VERDICT_REDIRECT;
        default:                 res.verdict = cfrl_pkg::VERDICT_DELIVER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_count_r    <= '0;
      window_start_r <= '0;
      lock_start_r   <= '0;
      lock_active_r  <= 1'b0;
    end else if (push && limiting) begin
      msg_count_r    <= msg_count_nxt;
      window_start_r <= window_start_nxt;
      lock_start_r   <= lock_start_nxt;
      lock_active_r  <= lock_active_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // two-entry result queue
  // --------------------------------------------------------------------------
  cfrl_pkg::result_t q_mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        fifo_cnt_r;

  assign in_tready  = (fifo_cnt_r != 2'd2);
  assign out_tvalid = (fifo_cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {6'd0, q_mem_r[rd_ptr_r].verdict};
  assign out_tuser  = q_mem_r[rd_ptr_r].flood_report;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + 2'd1;
        2'b01:   fifo_cnt_r <= fifo_cnt_r - 2'd1;
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= 2'd2)
    else $error("result queue overfilled");

  a_fifo_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> fifo_cnt_r == $past(fifo_cnt_r) - 2'd1)
    else $error("result queue count lost a pop");

  a_exempt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push && !limiting |=> $stable(msg_count_r) && $stable(lock_active_r))
    else $error("state changed for an unlimited message");

  a_drop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.verdict == cfrl_pkg::VERDICT_DROP |-> action_mode_r == cfrl_pkg::MODE_DROP)
    else $error("drop verdict outside drop mode");

  a_report_locks: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.flood_report |-> over_limit && report_enable_r)
    else $error("flood report without an excess message");
`endif

endmodule : chat_flood_rate_limiter
`default_nettype wire
